/* hdl/mvna_pkg.sv */
`default_nettype none
package mvna_pkg;

	localparam int VIDX_W = 10;
	localparam int NUM_VERT = 1024;
	localparam int COORD_W = 20;
	localparam int SUM_W = 24;
	localparam int CNT_W = 8;
	localparam int NRM_W = 16;
	localparam int DIFF_W = COORD_W + 1;
	localparam int CROSS_W = 44;
	localparam int SQ_W = 62;
	localparam int LEN_W = 31;
	localparam int DIV_NUM_W = 24;
	localparam int DIV_STEP_W = 5;
	localparam int FQ_DEPTH = 4;
	localparam int FQ_AW = 2;

	localparam logic [CNT_W-1:0] MAX_DEGREE = 8'd255;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_TRI = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	typedef logic [0:2][COORD_W-1:0] pos_t;
	typedef logic [0:2][VIDX_W-1:0] corners_t;

	typedef struct packed {
		logic [0:2][SUM_W-1:0] sum;
		logic [CNT_W-1:0] cnt;
	} acc_t;

	localparam int POS_W = $bits(pos_t);
	localparam int ACC_W = $bits(acc_t);

	typedef struct packed {
		logic [1:0] kind;
		logic [VIDX_W-1:0] vidx;
		pos_t pos;
		corners_t corner;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} fq_head_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} bk_stat_t;

	typedef struct packed {
		logic start;
		logic [LEN_W-1:0] rem;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_STEP_W-1:0] steps;
		logic [LEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DIV_NUM_W-1:0] quo;
	} div_rsp_t;

endpackage
`default_nettype wire

/* hdl/mvna_ifs.sv */
`default_nettype none
interface mvna_item_if;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [mvna_pkg::VIDX_W-1:0] vertex_index;
	logic signed [mvna_pkg::COORD_W-1:0] coord_x;
	logic signed [mvna_pkg::COORD_W-1:0] coord_y;
	logic signed [mvna_pkg::COORD_W-1:0] coord_z;
	logic [mvna_pkg::VIDX_W-1:0] corner_a;
	logic [mvna_pkg::VIDX_W-1:0] corner_b;
	logic [mvna_pkg::VIDX_W-1:0] corner_c;

	modport source(output valid, kind, vertex_index, coord_x, coord_y, coord_z,
		corner_a, corner_b, corner_c, input ready);
	modport sink(input valid, kind, vertex_index, coord_x, coord_y, coord_z,
		corner_a, corner_b, corner_c, output ready);
endinterface

interface mvna_nrm_if;
	logic valid;
	logic ready;
	logic [mvna_pkg::VIDX_W-1:0] normal_vertex;
	logic signed [mvna_pkg::NRM_W-1:0] normal_x;
	logic signed [mvna_pkg::NRM_W-1:0] normal_y;
	logic signed [mvna_pkg::NRM_W-1:0] normal_z;
	logic no_neighbors;

	modport source(output valid, normal_vertex, normal_x, normal_y, normal_z,
		no_neighbors, input ready);
	modport sink(input valid, normal_vertex, normal_x, normal_y, normal_z,
		no_neighbors, output ready);
endinterface
`default_nettype wire

/* hdl/mvna_ram.sv */
`default_nettype none
module mvna_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* hdl/mvna_div.sv */
`default_nettype none
module mvna_div (
	input  logic clk,
	input  logic arst_n,
	input  mvna_pkg::div_req_t req,
	output mvna_pkg::div_rsp_t rsp
);
	import mvna_pkg::*;

	logic busy_q;
	logic done_q;
	logic [DIV_STEP_W-1:0] cnt_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [LEN_W:0] trial;
	logic fits;

	// Restoring division, one quotient bit per cycle.
	assign trial = {rem_q, num_q[DIV_NUM_W-1]};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem;
			den_q <= req.den;
			num_q <= req.num;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? LEN_W'(trial - {1'b0, den_q}) : trial[LEN_W-1:0];
			num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;
endmodule
`default_nettype wire

/* hdl/mvna_front.sv */
`default_nettype none
module mvna_front (
	input  logic clk,
	input  logic arst_n,
	mvna_item_if.sink items,
	input  mvna_pkg::bk_stat_t stat,
	output mvna_pkg::fq_head_t head
);
	import mvna_pkg::*;

	cmd_t mem_q [FQ_DEPTH];
	logic [FQ_AW-1:0] wr_q;
	logic [FQ_AW-1:0] rd_q;
	logic [FQ_AW:0] cnt_q;
	logic xfer;
	logic push;

	assign items.ready = (cnt_q != (FQ_AW+1)'(FQ_DEPTH)) && !stat.clearing;
	assign xfer = items.valid && items.ready;
	// The unused kind is taken and dropped here; it never reaches the back end.
	assign push = xfer && (items.kind == KIND_LOAD || items.kind == KIND_TRI
		|| items.kind == KIND_READ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (stat.pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !stat.pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && stat.pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{kind: items.kind, vidx: items.vertex_index,
				pos: {items.coord_x, items.coord_y, items.coord_z},
				corner: {items.corner_a, items.corner_b, items.corner_c}};
		end
	end

	assign head.valid = cnt_q != '0;
	assign head.cmd = mem_q[rd_q];
endmodule
`default_nettype wire

/* hdl/mvna_back.sv */
`default_nettype none
module mvna_back (
	input  logic clk,
	input  logic arst_n,
	input  mvna_pkg::fq_head_t head,
	output mvna_pkg::bk_stat_t stat,
	mvna_nrm_if.source normals
);
	import mvna_pkg::*;

	localparam logic [4:0] S_CLEAR = 5'd0;
	localparam logic [4:0] S_IDLE = 5'd1;
	localparam logic [4:0] S_POS = 5'd2;
	localparam logic [4:0] S_DIFF = 5'd3;
	localparam logic [4:0] S_CROSS = 5'd4;
	localparam logic [4:0] S_CDRAIN = 5'd5;
	localparam logic [4:0] S_MAG = 5'd6;
	localparam logic [4:0] S_NORM = 5'd7;
	localparam logic [4:0] S_SQ = 5'd8;
	localparam logic [4:0] S_SQDRAIN = 5'd9;
	localparam logic [4:0] S_SQRT = 5'd10;
	localparam logic [4:0] S_NDIV_GO = 5'd11;
	localparam logic [4:0] S_NDIV_WT = 5'd12;
	localparam logic [4:0] S_ACC_RD = 5'd13;
	localparam logic [4:0] S_ACC_MOD = 5'd14;
	localparam logic [4:0] S_RD_WAIT = 5'd15;
	localparam logic [4:0] S_AVG_GO = 5'd16;
	localparam logic [4:0] S_AVG_WT = 5'd17;
	localparam logic [4:0] S_OUT = 5'd18;

	function automatic logic [VIDX_W-1:0] pick(input corners_t c, input logic [1:0] s);
		logic [VIDX_W-1:0] r;
		case (s)
			2'd0: r = c[0];
			2'd1: r = c[1];
			default: r = c[2];
		endcase
		return r;
	endfunction

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
		input logic [NRM_W-1:0] n);
		logic [SUM_W:0] r;
		r = {s[SUM_W-1], s} + {{(SUM_W+1-NRM_W){n[NRM_W-1]}}, n};
		if (r[SUM_W] != r[SUM_W-1]) begin
			r[SUM_W-1:0] = {r[SUM_W], {(SUM_W-1){~r[SUM_W]}}};
		end
		return r[SUM_W-1:0];
	endfunction

	logic [4:0] state_q;
	logic [VIDX_W-1:0] clr_q;
	logic [1:0] pcnt_q;
	logic [3:0] k_q;
	logic [1:0] comp_q;
	cmd_t cmd_q;

	pos_t p_q [3];
	logic signed [DIFF_W-1:0] u_q [3];
	logic signed [DIFF_W-1:0] w_q [3];
	logic [CROSS_W-1:0] c_q [3];
	logic [CROSS_W-1:0] a_q [3];
	logic neg_q [3];
	logic [SQ_W-1:0] x_q;
	logic [SQ_W-1:0] r_q;
	logic [SQ_W-1:0] bit_q;
	logic [NRM_W-1:0] nrm_q [3];
	logic [NRM_W-1:0] res_q [3];
	acc_t rd_q;
	logic nonb_q;

	logic out_valid_q;
	logic [VIDX_W-1:0] out_vert_q;
	logic [NRM_W-1:0] out_x_q;
	logic [NRM_W-1:0] out_y_q;
	logic [NRM_W-1:0] out_z_q;
	logic out_nonb_q;

	logic pos_we;
	logic [VIDX_W-1:0] pos_waddr;
	logic [VIDX_W-1:0] pos_raddr;
	pos_t pos_wdata;
	pos_t pos_rdata;
	logic acc_we;
	logic [VIDX_W-1:0] acc_waddr;
	logic [VIDX_W-1:0] acc_raddr;
	acc_t acc_wdata;
	acc_t acc_rdata;
	acc_t acc_new;
	logic [VIDX_W-1:0] corner_sel;

	logic mul_go;
	logic signed [31:0] op_a;
	logic signed [31:0] op_b;
	logic signed [63:0] prod_s1;
	logic [3:0] prodk_s1;
	logic prodv_s1;

	logic [SQ_W-1:0] sq_trial;
	logic [LEN_W-1:0] len;
	logic [45:0] nd_num;
	logic [SUM_W-1:0] s_sel;
	logic [SUM_W-1:0] s_mag;
	logic [DIV_NUM_W-1:0] q_sgn;
	logic [16:0] q_nrm;
	logic [NRM_W-1:0] q_sat;
	logic out_free;
	logic norm_zero;
	logic norm_hi;
	logic norm_lo;
	div_req_t div_req;
	div_rsp_t div_rsp;

	mvna_ram #(.WIDTH(POS_W), .DEPTH(NUM_VERT)) u_pos_ram (
		.clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
		.raddr(pos_raddr), .rdata(pos_rdata)
	);

	mvna_ram #(.WIDTH(ACC_W), .DEPTH(NUM_VERT)) u_acc_ram (
		.clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
		.raddr(acc_raddr), .rdata(acc_rdata)
	);

	mvna_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	assign corner_sel = pick(cmd_q.corner, comp_q);
	assign stat.pop = (state_q == S_IDLE) && head.valid;
	assign stat.clearing = state_q == S_CLEAR;
	assign out_free = !out_valid_q || normals.ready;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_new.sum[i] = sat_add(acc_rdata.sum[i], nrm_q[i]);
		end
		acc_new.cnt = acc_rdata.cnt + 1'b1;
	end

	always_comb begin
		pos_we = 1'b0;
		pos_waddr = head.cmd.vidx;
		pos_wdata = head.cmd.pos;
		pos_raddr = pick(cmd_q.corner, pcnt_q);
		acc_we = 1'b0;
		acc_waddr = clr_q;
		acc_wdata = '0;
		acc_raddr = head.cmd.vidx;
		case (state_q)
			S_CLEAR: begin
				acc_we = 1'b1;
			end
			S_IDLE: begin
				if (head.valid && head.cmd.kind == KIND_LOAD) begin
					pos_we = 1'b1;
					acc_we = 1'b1;
					acc_waddr = head.cmd.vidx;
				end
			end
			S_ACC_RD: begin
				acc_raddr = corner_sel;
			end
			S_ACC_MOD: begin
				// A corner at the degree limit keeps both its sums and its count.
				acc_we = acc_rdata.cnt < MAX_DEGREE;
				acc_waddr = corner_sel;
				acc_wdata = acc_new;
			end
			default: begin
			end
		endcase
	end

	// One shared multiplier: six cross-product terms, then three squares.
	assign mul_go = (state_q == S_CROSS) || (state_q == S_SQ);
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (k_q)
			4'd0: begin op_a = 32'(u_q[1]); op_b = 32'(w_q[2]); end
			4'd1: begin op_a = 32'(u_q[2]); op_b = 32'(w_q[1]); end
			4'd2: begin op_a = 32'(u_q[2]); op_b = 32'(w_q[0]); end
			4'd3: begin op_a = 32'(w_q[2]); op_b = 32'(u_q[0]); end
			4'd4: begin op_a = 32'(u_q[0]); op_b = 32'(w_q[1]); end
			4'd5: begin op_a = 32'(w_q[0]); op_b = 32'(u_q[1]); end
			4'd6: begin op_a = {2'b00, a_q[0][29:0]}; op_b = {2'b00, a_q[0][29:0]}; end
			4'd7: begin op_a = {2'b00, a_q[1][29:0]}; op_b = {2'b00, a_q[1][29:0]}; end
			4'd8: begin op_a = {2'b00, a_q[2][29:0]}; op_b = {2'b00, a_q[2][29:0]}; end
			default: begin end
		endcase
	end

	always_comb begin
		norm_zero = 1'b1;
		norm_hi = 1'b0;
		norm_lo = 1'b1;
		for (int i = 0; i < 3; i++) begin
			norm_zero = norm_zero && (a_q[i] == '0);
			norm_hi = norm_hi || (a_q[i][CROSS_W-1:30] != '0);
			norm_lo = norm_lo && (a_q[i][CROSS_W-1:29] == '0);
		end
	end

	assign sq_trial = r_q + bit_q;
	assign len = r_q[LEN_W-1:0];
	assign nd_num = {1'b0, a_q[comp_q][29:0], 15'd0} + {16'd0, len[LEN_W-1:1]};
	assign s_sel = rd_q.sum[comp_q];
	assign s_mag = s_sel[SUM_W-1] ? (~s_sel + 1'b1) : s_sel;
	assign q_sgn = rd_q.sum[comp_q][SUM_W-1] ? (~div_rsp.quo + 1'b1) : div_rsp.quo;
	assign q_nrm = div_rsp.quo[16:0];
	assign q_sat = (q_nrm[16:15] != 2'b00) ? 16'h7fff : q_nrm[15:0];

	always_comb begin
		div_req.start = (state_q == S_NDIV_GO) || (state_q == S_AVG_GO);
		if (state_q == S_AVG_GO) begin
			div_req.rem = '0;
			div_req.num = s_mag + {{(SUM_W-CNT_W+1){1'b0}}, rd_q.cnt[CNT_W-1:1]};
			div_req.steps = DIV_STEP_W'(DIV_NUM_W);
			div_req.den = {{(LEN_W-CNT_W){1'b0}}, rd_q.cnt};
		end else begin
			// The quotient fits in 17 bits, so the upper numerator bits preload
			// the remainder.
			div_req.rem = {2'b00, nd_num[45:17]};
			div_req.num = {nd_num[16:0], 7'd0};
			div_req.steps = DIV_STEP_W'(17);
			div_req.den = len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			pcnt_q <= '0;
			k_q <= '0;
			comp_q <= '0;
			prodv_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			prodv_s1 <= mul_go;
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (normals.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == VIDX_W'(NUM_VERT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					pcnt_q <= '0;
					comp_q <= '0;
					if (head.valid) begin
						if (head.cmd.kind == KIND_TRI) begin
							state_q <= S_POS;
						end else if (head.cmd.kind == KIND_READ) begin
							state_q <= S_RD_WAIT;
						end
					end
				end
				S_POS: begin
					pcnt_q <= pcnt_q + 1'b1;
					if (pcnt_q == 2'd3) begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					k_q <= '0;
					state_q <= S_CROSS;
				end
				S_CROSS: begin
					k_q <= k_q + 1'b1;
					if (k_q == 4'd5) begin
						state_q <= S_CDRAIN;
					end
				end
				S_CDRAIN: state_q <= S_MAG;
				S_MAG: state_q <= S_NORM;
				S_NORM: begin
					if (norm_zero) begin
						comp_q <= '0;
						state_q <= S_ACC_RD;
					end else if (!norm_hi && !norm_lo) begin
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					k_q <= k_q + 1'b1;
					if (k_q == 4'd8) begin
						state_q <= S_SQDRAIN;
					end
				end
				S_SQDRAIN: state_q <= S_SQRT;
				S_SQRT: begin
					comp_q <= '0;
					if (bit_q[0]) begin
						state_q <= S_NDIV_GO;
					end
				end
				S_NDIV_GO: state_q <= S_NDIV_WT;
				S_NDIV_WT: begin
					if (div_rsp.done) begin
						if (comp_q == 2'd2) begin
							comp_q <= '0;
							state_q <= S_ACC_RD;
						end else begin
							comp_q <= comp_q + 1'b1;
							state_q <= S_NDIV_GO;
						end
					end
				end
				S_ACC_RD: state_q <= S_ACC_MOD;
				S_ACC_MOD: begin
					if (comp_q == 2'd2) begin
						state_q <= S_IDLE;
					end else begin
						comp_q <= comp_q + 1'b1;
						state_q <= S_ACC_RD;
					end
				end
				S_RD_WAIT: begin
					state_q <= (acc_rdata.cnt == '0) ? S_OUT : S_AVG_GO;
				end
				S_AVG_GO: state_q <= S_AVG_WT;
				S_AVG_WT: begin
					if (div_rsp.done) begin
						if (comp_q == 2'd2) begin
							state_q <= S_OUT;
						end else begin
							comp_q <= comp_q + 1'b1;
							state_q <= S_AVG_GO;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		prodk_s1 <= k_q;
		if (stat.pop) begin
			cmd_q <= head.cmd;
		end
		if (state_q == S_POS && pcnt_q != 2'd0) begin
			p_q[0] <= p_q[1];
			p_q[1] <= p_q[2];
			p_q[2] <= pos_rdata;
		end
		if (state_q == S_DIFF) begin
			for (int i = 0; i < 3; i++) begin
				u_q[i] <= $signed({p_q[1][i][COORD_W-1], p_q[1][i]})
					- $signed({p_q[0][i][COORD_W-1], p_q[0][i]});
				w_q[i] <= $signed({p_q[2][i][COORD_W-1], p_q[2][i]})
					- $signed({p_q[1][i][COORD_W-1], p_q[1][i]});
			end
		end
		if (prodv_s1) begin
			case (prodk_s1)
				4'd0: c_q[0] <= prod_s1[CROSS_W-1:0];
				4'd1: c_q[0] <= c_q[0] - prod_s1[CROSS_W-1:0];
				4'd2: c_q[1] <= prod_s1[CROSS_W-1:0];
				4'd3: c_q[1] <= c_q[1] - prod_s1[CROSS_W-1:0];
				4'd4: c_q[2] <= prod_s1[CROSS_W-1:0];
				4'd5: c_q[2] <= c_q[2] - prod_s1[CROSS_W-1:0];
				4'd6: x_q <= prod_s1[SQ_W-1:0];
				default: x_q <= x_q + prod_s1[SQ_W-1:0];
			endcase
		end
		if (state_q == S_MAG) begin
			for (int i = 0; i < 3; i++) begin
				a_q[i] <= c_q[i][CROSS_W-1] ? (~c_q[i] + 1'b1) : c_q[i];
				neg_q[i] <= c_q[i][CROSS_W-1];
			end
		end
		// All three magnitudes move together until the largest sits in [2^29, 2^30).
		if (state_q == S_NORM) begin
			for (int i = 0; i < 3; i++) begin
				if (norm_zero) begin
					nrm_q[i] <= '0;
				end else if (norm_hi) begin
					a_q[i] <= a_q[i] >> 1;
				end else if (norm_lo) begin
					a_q[i] <= a_q[i] << 1;
				end
			end
		end
		if (state_q == S_SQDRAIN) begin
			r_q <= '0;
			bit_q <= SQ_W'(1) << 60;
		end
		if (state_q == S_SQRT) begin
			if (x_q >= sq_trial) begin
				x_q <= x_q - sq_trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (state_q == S_NDIV_WT && div_rsp.done) begin
			nrm_q[comp_q] <= neg_q[comp_q] ? (~q_sat + 1'b1) : q_sat;
		end
		if (state_q == S_RD_WAIT) begin
			rd_q <= acc_rdata;
			nonb_q <= acc_rdata.cnt == '0;
		end
		if (state_q == S_AVG_WT && div_rsp.done) begin
			res_q[comp_q] <= q_sgn[NRM_W-1:0];
		end
		if (state_q == S_OUT && out_free) begin
			out_vert_q <= cmd_q.vidx;
			out_x_q <= nonb_q ? '0 : res_q[0];
			out_y_q <= nonb_q ? '0 : res_q[1];
			out_z_q <= nonb_q ? '0 : res_q[2];
			out_nonb_q <= nonb_q;
		end
	end

	assign normals.valid = out_valid_q;
	assign normals.normal_vertex = out_vert_q;
	assign normals.normal_x = out_x_q;
	assign normals.normal_y = out_y_q;
	assign normals.normal_z = out_z_q;
	assign normals.no_neighbors = out_nonb_q;
endmodule
`default_nettype wire

/* hdl/mesh_vertex_normal_averager.sv */
`default_nettype none
// Averaged per-vertex normals of a triangle mesh.
// Items arrive on the items channel and a read item returns one transfer on
// the normals channel; load and triangle items return nothing. Both channels
// transfer when valid and ready are high at a rising clock edge.
// A four-entry queue sits between the input side and the execution sequencer,
// so items are taken while earlier ones are still being worked on.
// In the sequencer a load needs no state beyond idle. A read takes three
// passes of the shared radix-2 divider (24 steps each), or none when the
// vertex has no neighbors. A triangle takes three position reads, six
// products on the shared multiplier, a one-bit-per-cycle normalizing
// shift, a 31-step square root, three 17-step divisions and three
// read-modify-writes of the accumulator memory; a zero normal skips the
// middle part. After reset the accumulator memory is swept to zero with
// items.ready held low. A stalled result waits in the output register; the
// sequencer stops only when a second result is ready behind it.
module mesh_vertex_normal_averager (
	input  logic clk,
	input  logic arst_n,
	mvna_item_if.sink items,
	mvna_nrm_if.source normals
);
	import mvna_pkg::*;

	fq_head_t head;
	bk_stat_t stat;

	mvna_front u_front (
		.clk(clk), .arst_n(arst_n), .items(items), .stat(stat), .head(head)
	);

	mvna_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .stat(stat), .normals(normals)
	);

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !items.ready)
		else $error("item taken during the clearing sweep");

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		stat.pop |-> head.valid)
		else $error("queue popped while empty");

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !normals.valid)
		else $error("result offered during the clearing sweep");
endmodule
`default_nettype wire
